@@ hdl/fsrcf_pkg.sv @@
package fsrcf_pkg;

	localparam int unsigned BLOCK_INDEX_BITS_DEFAULT = 32;
	localparam int unsigned SIZE_BITS = 32;
	localparam int unsigned RESULT_BITS = 32;
	localparam int unsigned CFG_INDEX_BITS = 2;

	typedef enum logic [1:0] {
		CLASS_NONE  = 2'd0,
		CLASS_BODY  = 2'd1,
		CLASS_PART  = 2'd2,
		CLASS_WHOLE = 2'd3
	} run_class_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SIZE_BODY      = 2'd0,
		REG_SIZE_WITH_PART = 2'd1,
		REG_SIZE_WHOLE     = 2'd2
	} cfg_reg_t;

	// per-item control from the run tracker to the class keeper
	typedef struct packed {
		logic advance;
		logic judge;
		logic last;
	} judge_ctl_t;

endpackage

@@ hdl/free_run_size_class_finder.sv @@
// Free run size class finder.
// Bitmap blocks stream in on the input channel (in_valid/in_ready), one transfer per
// block, starting at block 0: used_bit, reserved_bit and last_block. Runs of free
// blocks are classed against size_body, size_with_part and size_whole, written
// through the cfg_valid/cfg_ready port (cfg_index 0, 1, 2; other indexes ignored).
// One result transfer (found_class, run_start, run_length) follows each block that
// carries last_block: the best class seen and the first run of that class.
// Once a class 3 run is found, the remaining blocks up to the last are discarded.
// Throughput: one block per cycle, but for a last block held by a pending result; the
// run update and the three threshold compares lie between the input and result registers.
// The last block passes the input register, then the result register raises out_valid.
// The result register holds while out_ready is low; non-last blocks keep flowing,
// and a last block waits in the input register until the pending result is taken.
// Reset clears the scan state and sets all three thresholds to 1; config ports are
// always ready and take effect at once.
module free_run_size_class_finder #(
	parameter int unsigned BLOCK_INDEX_BITS = fsrcf_pkg::BLOCK_INDEX_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fsrcf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [fsrcf_pkg::SIZE_BITS-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  used_bit,
	input  logic                                  reserved_bit,
	input  logic                                  last_block,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            found_class,
	output logic [fsrcf_pkg::RESULT_BITS-1:0]     run_start,
	output logic [fsrcf_pkg::RESULT_BITS-1:0]     run_length
);

	logic [fsrcf_pkg::SIZE_BITS-1:0]   size_body_q, size_with_part_q, size_whole_q;
	logic                              valid_s1, used_s1, reserved_s1, last_s1;
	logic                              advance, frozen;
	logic                              out_valid_q;
	fsrcf_pkg::run_class_t             class_q, res_class;
	logic [fsrcf_pkg::RESULT_BITS-1:0] start_q, len_q, res_start, res_len;
	fsrcf_pkg::judge_ctl_t             ctl;
	logic [BLOCK_INDEX_BITS-1:0]       judge_start, judge_len;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_body_q      <= fsrcf_pkg::SIZE_BITS'(1);
			size_with_part_q <= fsrcf_pkg::SIZE_BITS'(1);
			size_whole_q     <= fsrcf_pkg::SIZE_BITS'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				fsrcf_pkg::REG_SIZE_BODY:      size_body_q      <= cfg_data;
				fsrcf_pkg::REG_SIZE_WITH_PART: size_with_part_q <= cfg_data;
				fsrcf_pkg::REG_SIZE_WHOLE:     size_whole_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// a last block needs a free result register
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			used_s1     <= used_bit;
			reserved_s1 <= reserved_bit;
			last_s1     <= last_block;
		end
	end

	fsrcf_run_tracker #(
		.BLOCK_INDEX_BITS(BLOCK_INDEX_BITS)
	) u_run_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.frozen     (frozen),
		.used       (used_s1),
		.reserved   (reserved_s1),
		.last       (last_s1),
		.ctl        (ctl),
		.judge_start(judge_start),
		.judge_len  (judge_len)
	);

	fsrcf_class_keeper #(
		.BLOCK_INDEX_BITS(BLOCK_INDEX_BITS)
	) u_class_keeper (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.judge_start   (judge_start),
		.judge_len     (judge_len),
		.size_body     (size_body_q),
		.size_with_part(size_with_part_q),
		.size_whole    (size_whole_q),
		.frozen        (frozen),
		.res_class     (res_class),
		.res_start     (res_start),
		.res_len       (res_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			class_q <= res_class;
			start_q <= res_start;
			len_q   <= res_len;
		end
	end

	assign out_valid   = out_valid_q;
	assign found_class = class_q;
	assign run_start   = start_q;
	assign run_length  = len_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(advance && last_s1))
		else $error("pending result overwritten");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(last_s1) && $past(valid_s1))
		else $error("result raised without a last block");

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (class_q == fsrcf_pkg::CLASS_NONE) |-> (start_q == '0) && (len_q == '0))
		else $error("class none with a nonzero run");

	a_scan_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> !frozen)
		else $error("scan state not cleared after last block");

endmodule

@@ hdl/fsrcf_run_tracker.sv @@
module fsrcf_run_tracker #(
	parameter int unsigned BLOCK_INDEX_BITS = fsrcf_pkg::BLOCK_INDEX_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        frozen,
	input  logic                        used,
	input  logic                        reserved,
	input  logic                        last,
	output fsrcf_pkg::judge_ctl_t       ctl,
	output logic [BLOCK_INDEX_BITS-1:0] judge_start,
	output logic [BLOCK_INDEX_BITS-1:0] judge_len
);

	localparam logic [BLOCK_INDEX_BITS-1:0] LEN_MAX = '1;

	logic [BLOCK_INDEX_BITS-1:0] pos_q;
	logic [BLOCK_INDEX_BITS-1:0] start_q;
	logic [BLOCK_INDEX_BITS-1:0] len_q;
	logic [BLOCK_INDEX_BITS-1:0] inc_len;
	logic [BLOCK_INDEX_BITS-1:0] run_start;
	logic                        is_free;

	always_comb begin
		is_free   = !used && !reserved && (pos_q != '0);
		inc_len   = (len_q == LEN_MAX) ? len_q : len_q + BLOCK_INDEX_BITS'(1);
		run_start = (len_q == '0) ? pos_q : start_q;
		// if not frozen, a taken block closes the run; a free one only on the last item
		judge_start = is_free ? run_start : start_q;
		judge_len   = is_free ? inc_len : len_q;
		ctl.advance = advance;
		ctl.last    = last;
		ctl.judge   = advance && !frozen && (!is_free || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
		end else if (advance) begin
			if (last) begin
				pos_q   <= '0;
				start_q <= '0;
				len_q   <= '0;
			end else if (!frozen) begin
				pos_q <= pos_q + BLOCK_INDEX_BITS'(1);
				if (is_free) begin
					start_q <= run_start;
					len_q   <= inc_len;
				end else begin
					len_q <= '0;
				end
			end
		end
	end

endmodule

@@ hdl/fsrcf_class_keeper.sv @@
module fsrcf_class_keeper #(
	parameter int unsigned BLOCK_INDEX_BITS = fsrcf_pkg::BLOCK_INDEX_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fsrcf_pkg::judge_ctl_t                ctl,
	input  logic [BLOCK_INDEX_BITS-1:0]          judge_start,
	input  logic [BLOCK_INDEX_BITS-1:0]          judge_len,
	input  logic [fsrcf_pkg::SIZE_BITS-1:0]      size_body,
	input  logic [fsrcf_pkg::SIZE_BITS-1:0]      size_with_part,
	input  logic [fsrcf_pkg::SIZE_BITS-1:0]      size_whole,
	output logic                                 frozen,
	output fsrcf_pkg::run_class_t                res_class,
	output logic [fsrcf_pkg::RESULT_BITS-1:0]    res_start,
	output logic [fsrcf_pkg::RESULT_BITS-1:0]    res_len
);

	localparam int unsigned CMP_BITS = (BLOCK_INDEX_BITS > fsrcf_pkg::SIZE_BITS) ?
		BLOCK_INDEX_BITS : fsrcf_pkg::SIZE_BITS;
	localparam int unsigned EXT_BITS = (CMP_BITS > fsrcf_pkg::RESULT_BITS) ?
		CMP_BITS : fsrcf_pkg::RESULT_BITS;

	fsrcf_pkg::run_class_t       best_q, best_d, run_cls;
	logic [BLOCK_INDEX_BITS-1:0] c3_start_q, c3_len_q, c2_start_q, c2_len_q;
	logic [BLOCK_INDEX_BITS-1:0] c1_start_q, c1_len_q;
	logic [BLOCK_INDEX_BITS-1:0] c3_start_d, c3_len_d, c2_start_d, c2_len_d;
	logic [BLOCK_INDEX_BITS-1:0] c1_start_d, c1_len_d;
	logic [BLOCK_INDEX_BITS-1:0] sel_start, sel_len;
	logic [EXT_BITS-1:0]         sel_start_ext, sel_len_ext;
	logic [CMP_BITS-1:0]         len_ext;
	logic                        take;

	assign frozen = (best_q == fsrcf_pkg::CLASS_WHOLE);

	always_comb begin
		len_ext = CMP_BITS'(judge_len);
		// tests in fixed order, whatever the threshold values
		if (len_ext >= CMP_BITS'(size_whole)) begin
			run_cls = fsrcf_pkg::CLASS_WHOLE;
		end else if (len_ext >= CMP_BITS'(size_with_part)) begin
			run_cls = fsrcf_pkg::CLASS_PART;
		end else if (len_ext >= CMP_BITS'(size_body)) begin
			run_cls = fsrcf_pkg::CLASS_BODY;
		end else begin
			run_cls = fsrcf_pkg::CLASS_NONE;
		end
		take = ctl.judge && (judge_len != '0) && (best_q < run_cls);

		best_d     = best_q;
		c3_start_d = c3_start_q;
		c3_len_d   = c3_len_q;
		c2_start_d = c2_start_q;
		c2_len_d   = c2_len_q;
		c1_start_d = c1_start_q;
		c1_len_d   = c1_len_q;
		if (take) begin
			best_d = run_cls;
			case (run_cls)
				fsrcf_pkg::CLASS_WHOLE: begin
					c3_start_d = judge_start;
					c3_len_d   = judge_len;
				end
				fsrcf_pkg::CLASS_PART: begin
					c2_start_d = judge_start;
					c2_len_d   = judge_len;
				end
				fsrcf_pkg::CLASS_BODY: begin
					c1_start_d = judge_start;
					c1_len_d   = judge_len;
				end
				default: begin
				end
			endcase
		end

		case (best_d)
			fsrcf_pkg::CLASS_WHOLE: begin
				sel_start = c3_start_d;
				sel_len   = c3_len_d;
			end
			fsrcf_pkg::CLASS_PART: begin
				sel_start = c2_start_d;
				sel_len   = c2_len_d;
			end
			fsrcf_pkg::CLASS_BODY: begin
				sel_start = c1_start_d;
				sel_len   = c1_len_d;
			end
			default: begin
				sel_start = '0;
				sel_len   = '0;
			end
		endcase
		res_class     = best_d;
		sel_start_ext = EXT_BITS'(sel_start);
		sel_len_ext   = EXT_BITS'(sel_len);
		res_start     = sel_start_ext[fsrcf_pkg::RESULT_BITS-1:0];
		res_len       = sel_len_ext[fsrcf_pkg::RESULT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= fsrcf_pkg::CLASS_NONE;
			c3_start_q <= '0;
			c3_len_q   <= '0;
			c2_start_q <= '0;
			c2_len_q   <= '0;
			c1_start_q <= '0;
			c1_len_q   <= '0;
		end else if (ctl.advance && ctl.last) begin
			best_q     <= fsrcf_pkg::CLASS_NONE;
			c3_start_q <= '0;
			c3_len_q   <= '0;
			c2_start_q <= '0;
			c2_len_q   <= '0;
			c1_start_q <= '0;
			c1_len_q   <= '0;
		end else begin
			best_q     <= best_d;
			c3_start_q <= c3_start_d;
			c3_len_q   <= c3_len_d;
			c2_start_q <= c2_start_d;
			c2_len_q   <= c2_len_d;
			c1_start_q <= c1_start_d;
			c1_len_q   <= c1_len_d;
		end
	end

endmodule
